// ===== rtl/assert_macros.svh =====
// assertion macros for the top level of the quadratic solver
// depends on nothing; the including module supplies i_clk and i_rst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/qes_pkg.sv =====
// package of the quadratic solver: widths, payload and sideband types, root emit function
// depends on nothing
package qes_pkg;

    localparam int COEF_WIDTH = 32;
    localparam int FRAC_BITS  = 16;

    // derived widths
    localparam int CW   = COEF_WIDTH;
    localparam int DW   = 2 * CW + 1;          // discriminant
    localparam int SW   = CW + 1;              // square root
    localparam int RW   = SW + 2;              // square root remainder
    localparam int NW   = CW + 2;              // numerator magnitude
    localparam int NSW  = NW + 1;              // signed numerator
    localparam int DENW = CW + 1;              // denominator
    localparam int DVW  = DENW + 1;            // doubled denominator
    localparam int NNW  = NW + FRAC_BITS + 2;  // scaled dividend and quotient

    typedef struct packed {
        logic signed [CW-1:0] coef_square;
        logic signed [CW-1:0] coef_linear;
        logic signed [CW-1:0] coef_constant;
    } t_req;

    typedef struct packed {
        logic        [1:0]    root_count;
        logic signed [CW-1:0] root_first;
        logic signed [CW-1:0] root_second;
        logic                 saturated;
    } t_rsp;

    // coefficient magnitudes and signs up to the root stage
    typedef struct packed {
        logic [CW-1:0] am;
        logic [CW-1:0] bm;
        logic [CW-1:0] cm;
        logic          an;
        logic          bn;
        logic          cn;
        logic          dneg;
    } t_side;

    // result control through the divider
    typedef struct packed {
        logic [1:0] count;
        logic       use1;
        logic       use2;
        logic       neg1;
        logic       neg2;
    } t_tag;

    // clip a quotient magnitude and apply its sign: {saturated, code}
    function automatic logic [CW:0] f_emit(input logic [NNW-1:0] q, input logic neg);
        logic [NNW-1:0] lim;
        logic           sat;
        logic [CW-1:0]  m;
        lim = neg ? (NNW'(1) << (CW - 1)) : ((NNW'(1) << (CW - 1)) - NNW'(1));
        sat = q > lim;
        m   = sat ? lim[CW-1:0] : q[CW-1:0];
        return {sat, neg ? (~m + CW'(1)) : m};
    endfunction

endpackage

// ===== rtl/qes_if.sv =====
// request and response channel interfaces of the quadratic solver
// depends on qes_pkg
interface qes_req_if;
    import qes_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface qes_rsp_if;
    import qes_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/qes_sqrt_pipe.sv =====
// pipelined floor square root of the discriminant, one result bit per stage
// depends on qes_pkg
module qes_sqrt_pipe (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic                      i_valid,
    input  qes_pkg::t_side            i_side,
    input  logic [qes_pkg::DW-1:0]    i_d,
    output logic                      o_valid,
    output qes_pkg::t_side            o_side,
    output logic [qes_pkg::SW-1:0]    o_root
);
    import qes_pkg::*;

    logic              r_v    [SW];
    t_side             r_side [SW];
    logic [2*SW-1:0]   r_d    [SW];
    logic [SW-1:0]     r_root [SW];
    logic [RW-1:0]     r_rem  [SW];

    for (genvar j = 0; j < SW; j++) begin : g_stage
        logic            p_v;
        t_side           p_side;
        logic [2*SW-1:0] p_d;
        logic [SW-1:0]   p_root;
        logic [RW-1:0]   p_rem;
        logic [RW:0]     w_sh;
        logic [RW:0]     w_trial;
        logic            w_ge;

        // previous stage or block input
        if (j == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_side = i_side;
            assign p_d    = (2*SW)'(i_d);
            assign p_root = '0;
            assign p_rem  = '0;
        end else begin : g_next
            assign p_v    = r_v[j-1];
            assign p_side = r_side[j-1];
            assign p_d    = r_d[j-1];
            assign p_root = r_root[j-1];
            assign p_rem  = r_rem[j-1];
        end

        // bring down the next bit pair and try the trial subtrahend
        assign w_sh    = {p_rem[RW-2:0], p_d[2*(SW-1-j)+1 -: 2]};
        assign w_trial = (RW+1)'({p_root, 2'b01});
        assign w_ge    = w_sh >= w_trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_adv) begin
                r_v[j] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_side[j] <= p_side;
                r_d[j]    <= p_d;
                r_rem[j]  <= w_ge ? RW'(w_sh - w_trial) : RW'(w_sh);
                r_root[j] <= {p_root[SW-2:0], w_ge};
            end
        end
    end

    assign o_valid = r_v[SW-1];
    assign o_side  = r_side[SW-1];
    assign o_root  = r_root[SW-1];

endmodule

// ===== rtl/qes_div_pipe.sv =====
// two-lane pipelined restoring divider with round half away from zero
// depends on qes_pkg; both lanes share one denominator
module qes_div_pipe (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic                      i_valid,
    input  qes_pkg::t_tag             i_tag,
    input  logic [qes_pkg::NW-1:0]    i_mag1,
    input  logic [qes_pkg::NW-1:0]    i_mag2,
    input  logic [qes_pkg::DENW-1:0]  i_den,
    output logic                      o_valid,
    output qes_pkg::t_tag             o_tag,
    output logic [qes_pkg::NNW-1:0]   o_q1,
    output logic [qes_pkg::NNW-1:0]   o_q2
);
    import qes_pkg::*;

    logic              r_ev;
    t_tag              r_etag;
    logic [DVW-1:0]    r_edv;
    logic [NNW-1:0]    r_en [2];

    logic              r_v   [NNW];
    t_tag              r_tag [NNW];
    logic [DVW-1:0]    r_dv  [NNW];
    logic [DVW-1:0]    r_rem [NNW][2];
    logic [NNW-1:0]    r_nq  [NNW][2];

    // entry: scaled dividend 2*mag*2^f + den over divisor 2*den
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 1'b0;
        end else if (i_adv) begin
            r_ev <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_etag  <= i_tag;
            r_edv   <= {i_den, 1'b0};
            r_en[0] <= (NNW'(i_mag1) << (FRAC_BITS + 1)) + NNW'(i_den);
            r_en[1] <= (NNW'(i_mag2) << (FRAC_BITS + 1)) + NNW'(i_den);
        end
    end

    for (genvar j = 0; j < NNW; j++) begin : g_stage
        logic           p_v;
        t_tag           p_tag;
        logic [DVW-1:0] p_dv;

        if (j == 0) begin : g_first
            assign p_v   = r_ev;
            assign p_tag = r_etag;
            assign p_dv  = r_edv;
        end else begin : g_next
            assign p_v   = r_v[j-1];
            assign p_tag = r_tag[j-1];
            assign p_dv  = r_dv[j-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_adv) begin
                r_v[j] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                r_tag[j] <= p_tag;
                r_dv[j]  <= p_dv;
            end
        end

        for (genvar l = 0; l < 2; l++) begin : g_lane
            logic [DVW-1:0] p_rem;
            logic [NNW-1:0] p_nq;
            logic [DVW:0]   w_sh;
            logic           w_ge;

            if (j == 0) begin : g_first
                assign p_rem = '0;
                assign p_nq  = r_en[l];
            end else begin : g_next
                assign p_rem = r_rem[j-1][l];
                assign p_nq  = r_nq[j-1][l];
            end

            // one quotient bit: shift in a dividend bit, subtract if it fits
            assign w_sh = {p_rem, p_nq[NNW-1]};
            assign w_ge = w_sh >= {1'b0, p_dv};

            always_ff @(posedge i_clk) begin
                if (i_adv) begin
                    r_rem[j][l] <= w_ge ? DVW'(w_sh - {1'b0, p_dv}) : DVW'(w_sh);
                    r_nq[j][l]  <= {p_nq[NNW-2:0], w_ge};
                end
            end
        end
    end

    assign o_valid = r_v[NNW-1];
    assign o_tag   = r_tag[NNW-1];
    assign o_q1    = r_nq[NNW-1][0];
    assign o_q2    = r_nq[NNW-1][1];

endmodule

// ===== rtl/quadratic_equation_solver.sv =====
// top level of the quadratic solver: coefficient split, products, discriminant, root setup,
// result clipping; depends on qes_pkg, qes_if, qes_sqrt_pipe, qes_div_pipe, assert_macros.svh

// Fully pipelined real-root solver for a*x^2+b*x+c=0 on signed Q16.16 coefficients. It
// accepts one request per clock while not stalled and returns one response per request, in
// order, through 3 front stages, 33 square-root stages, 1 setup stage, 1 + 52 divider stages
// and 1 output register; the depth is set by the bit-per-stage square root and divider.
// The whole pipeline advances when the output register is empty or being taken, so a
// response not taken holds every stage and ready falls. The discriminant is exact, the
// square root is the floor, roots are rounded half away from zero and clipped to Q16.16 with
// the saturated flag set. A zero a gives the linear root -c/b, one root at zero when b and c
// are both zero, and none when only b is zero.
module quadratic_equation_solver (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qes_req_if.sink   i_req,
    qes_rsp_if.source o_rsp
);
    import qes_pkg::*;

    logic          w_adv;

    logic          r_v1;
    t_side         r_s1;
    logic          r_v2;
    t_side         r_s2;
    logic [2*CW-1:0] r_bb;
    logic [2*CW-1:0] r_ac;
    logic          r_v3;
    t_side         r_s3;
    logic [DW-1:0] r_d;

    logic          w_sq_v;
    t_side         w_sq_side;
    logic [SW-1:0] w_root;

    logic          r_v4;
    t_tag          r_tag4;
    logic [NW-1:0] r_mag1;
    logic [NW-1:0] r_mag2;
    logic [DENW-1:0] r_den;

    logic          w_dv_v;
    t_tag          w_dv_tag;
    logic [NNW-1:0] w_q1;
    logic [NNW-1:0] w_q2;

    logic          r_out_valid;
    t_rsp          r_rsp;

    // global advance: output empty or taken
    assign w_adv       = !r_out_valid || o_rsp.ready;
    assign i_req.ready = w_adv;

    // stage 1: signs and magnitudes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_req.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= w_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1.an   <= i_req.data.coef_square[CW-1];
            r_s1.bn   <= i_req.data.coef_linear[CW-1];
            r_s1.cn   <= i_req.data.coef_constant[CW-1];
            r_s1.am   <= i_req.data.coef_square[CW-1] ? CW'(-i_req.data.coef_square)
                                                      : i_req.data.coef_square;
            r_s1.bm   <= i_req.data.coef_linear[CW-1] ? CW'(-i_req.data.coef_linear)
                                                      : i_req.data.coef_linear;
            r_s1.cm   <= i_req.data.coef_constant[CW-1] ? CW'(-i_req.data.coef_constant)
                                                        : i_req.data.coef_constant;
            r_s1.dneg <= 1'b0;
        end
    end

    // stage 2: b*b and a*c
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2 <= r_s1;
            r_bb <= r_s1.bm * r_s1.bm;
            r_ac <= r_s1.am * r_s1.cm;
        end
    end

    // stage 3: discriminant magnitude and sign
    logic [2*CW+1:0] w_bb;
    logic [2*CW+1:0] w_ac4;
    logic            w_acneg;
    logic [DW-1:0]   n_d;
    t_side           n_s3;

    assign w_bb    = (2*CW+2)'(r_bb);
    assign w_ac4   = (2*CW+2)'(r_ac) << 2;
    assign w_acneg = (r_s2.an ^ r_s2.cn) && (r_s2.cm != '0);

    always_comb begin
        n_s3 = r_s2;
        priority if (w_acneg) begin
            n_d       = DW'(w_bb + w_ac4);
            n_s3.dneg = 1'b0;
        end else if (w_bb >= w_ac4) begin
            n_d       = DW'(w_bb - w_ac4);
            n_s3.dneg = 1'b0;
        end else begin
            n_d       = '0;
            n_s3.dneg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3 <= n_s3;
            r_d  <= n_d;
        end
    end

    qes_sqrt_pipe u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_v3),
        .i_side  (r_s3),
        .i_d     (r_d),
        .o_valid (w_sq_v),
        .o_side  (w_sq_side),
        .o_root  (w_root)
    );

    // root setup: numerators -b -/+ s or c, denominator 2a or b, signs and count
    logic signed [NSW-1:0] w_nb;
    logic signed [NSW-1:0] w_s;
    logic signed [NSW-1:0] w_n1;
    logic signed [NSW-1:0] w_n2;
    logic signed [NSW-1:0] w_a1;
    logic signed [NSW-1:0] w_a2;
    logic                  w_az;
    logic                  w_bz;
    logic                  w_cz;
    t_tag                  n_tag4;

    assign w_s  = $signed(NSW'(w_root));
    assign w_nb = w_sq_side.bn ? $signed(NSW'(w_sq_side.bm)) : -$signed(NSW'(w_sq_side.bm));
    assign w_n1 = w_nb - w_s;
    assign w_n2 = w_nb + w_s;
    assign w_a1 = w_n1[NSW-1] ? -w_n1 : w_n1;
    assign w_a2 = w_n2[NSW-1] ? -w_n2 : w_n2;
    assign w_az = w_sq_side.am == '0;
    assign w_bz = w_sq_side.bm == '0;
    assign w_cz = w_sq_side.cm == '0;

    always_comb begin
        n_tag4 = '0;
        if (w_az) begin
            if (w_bz) begin
                n_tag4.count = w_cz ? 2'd1 : 2'd0;
            end else begin
                n_tag4.count = 2'd1;
                n_tag4.use1  = 1'b1;
                n_tag4.neg1  = !w_cz && !(w_sq_side.cn ^ w_sq_side.bn);
            end
        end else if (!w_sq_side.dneg) begin
            n_tag4.use1  = 1'b1;
            n_tag4.neg1  = w_n1[NSW-1] ^ w_sq_side.an;
            n_tag4.neg2  = w_n2[NSW-1] ^ w_sq_side.an;
            n_tag4.count = (w_root == '0) ? 2'd1 : 2'd2;
            n_tag4.use2  = w_root != '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_tag4 <= n_tag4;
            if (w_az) begin
                r_mag1 <= NW'(w_sq_side.cm);
                r_mag2 <= '0;
                r_den  <= DENW'(w_sq_side.bm);
            end else begin
                r_mag1 <= NW'(w_a1);
                r_mag2 <= NW'(w_a2);
                r_den  <= {w_sq_side.am, 1'b0};
            end
        end
    end

    qes_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (r_v4),
        .i_tag   (r_tag4),
        .i_mag1  (r_mag1),
        .i_mag2  (r_mag2),
        .i_den   (r_den),
        .o_valid (w_dv_v),
        .o_tag   (w_dv_tag),
        .o_q1    (w_q1),
        .o_q2    (w_q2)
    );

    // output register: clip, sign, mask unused roots
    logic [CW:0] w_e1;
    logic [CW:0] w_e2;

    assign w_e1 = f_emit(w_q1, w_dv_tag.neg1);
    assign w_e2 = f_emit(w_q2, w_dv_tag.neg2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_dv_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rsp.root_count  <= w_dv_tag.count;
            r_rsp.root_first  <= w_dv_tag.use1 ? $signed(w_e1[CW-1:0]) : '0;
            r_rsp.root_second <= w_dv_tag.use2 ? $signed(w_e2[CW-1:0]) : '0;
            r_rsp.saturated   <= (w_dv_tag.use1 && w_e1[CW]) || (w_dv_tag.use2 && w_e2[CW]);
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_rsp;

    // checks
    logic w_chk_partial;
    logic w_chk_none;
    logic w_chk_clean;

    assign w_chk_partial = o_rsp.valid && o_rsp.data.root_count != 2'd2;
    assign w_chk_none    = o_rsp.valid && o_rsp.data.root_count == 2'd0;
    assign w_chk_clean   = !o_rsp.data.saturated && o_rsp.data.root_first == '0;

    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_ready_adv, i_req.ready == (!o_rsp.valid || o_rsp.ready), "ready mismatch")
    `ASSERT_IMPLY(a_count_range, o_rsp.valid, o_rsp.data.root_count != 2'd3, "bad root count")
    `ASSERT_IMPLY(a_second_unused, w_chk_partial, o_rsp.data.root_second == '0, "stale root")
    `ASSERT_IMPLY(a_no_root_clean, w_chk_none, w_chk_clean, "empty response not cleared")

endmodule

// ===== tb/tb.sv =====
// testbench of the quadratic solver: directed table, then random coefficient sets
// checked against an in-bench root predictor; depends on qes_pkg, qes_if, quadratic_equation_solver
module tb;
    import qes_pkg::*;

    localparam int N_RANDOM = 800;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 200;

    typedef logic [127:0] t_wide;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    qes_req_if req_ch ();
    qes_rsp_if rsp_ch ();

    quadratic_equation_solver uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    t_rsp expected_roots[$];
    int   n_errors;
    int   n_checked;
    int   n_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", n_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic t_wide floor_sqrt(input t_wide v);
        t_wide res;
        t_wide bt;
        res = '0;
        bt  = t_wide'(1) << 66;
        while (bt != 0 && v < bt) bt = bt >> 2;
        while (bt != 0) begin
            if (v >= res + bt) begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    // scaled quotient of magnitudes, half away from zero
    function automatic t_wide scaled_quotient(input t_wide num, input t_wide den);
        t_wide n;
        n = num << FRAC_BITS;
        return ((n << 1) + den) / (den << 1);
    endfunction

    function automatic logic [CW-1:0] clip_root(input t_wide mag, input bit neg,
                                                inout bit sat);
        t_wide lim;
        lim = neg ? (t_wide'(1) << (CW - 1)) : ((t_wide'(1) << (CW - 1)) - 1);
        if (mag > lim) begin
            sat = 1'b1;
            mag = lim;
        end
        return neg ? CW'(-mag) : CW'(mag);
    endfunction

    // predicted roots of one coefficient set
    function automatic t_rsp predict_roots(input t_req r);
        t_rsp   o;
        longint la, lb, lc, nb, s, n1, n2;
        t_wide  am, bm, cm, bb, ac4, d;
        bit     an, bn, cn, sat, dneg;
        la = r.coef_square;
        lb = r.coef_linear;
        lc = r.coef_constant;
        an = la < 0;
        bn = lb < 0;
        cn = lc < 0;
        am = t_wide'(an ? -la : la);
        bm = t_wide'(bn ? -lb : lb);
        cm = t_wide'(cn ? -lc : lc);
        o = '0;
        sat = 1'b0;
        if (am == 0) begin
            if (bm == 0 && cm == 0) begin
                o.root_count = 2'd1;
            end else if (bm != 0) begin
                o.root_count = 2'd1;
                o.root_first = clip_root(scaled_quotient(cm, bm), cm != 0 && !(cn ^ bn), sat);
            end
        end else begin
            bb = bm * bm;
            ac4 = (am * cm) << 2;
            dneg = 1'b0;
            d = '0;
            if ((an ^ cn) && cm != 0) d = bb + ac4;
            else if (bb >= ac4) d = bb - ac4;
            else dneg = 1'b1;
            if (!dneg) begin
                s  = longint'(floor_sqrt(d));
                nb = bn ? longint'(bm) : -longint'(bm);
                n1 = nb - s;
                n2 = nb + s;
                o.root_first = clip_root(scaled_quotient(t_wide'(n1 < 0 ? -n1 : n1), am << 1),
                                         (n1 < 0) ^ an, sat);
                if (s == 0) begin
                    o.root_count = 2'd1;
                end else begin
                    o.root_count = 2'd2;
                    o.root_second = clip_root(
                        scaled_quotient(t_wide'(n2 < 0 ? -n2 : n2), am << 1),
                        (n2 < 0) ^ an, sat);
                end
            end
        end
        o.saturated = sat;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
        n_errors++;
        $display("mismatch at cycle %0d: %s expected %0h got %0h", n_cycles, what, exp_v, got_v);
    endtask

    // response checker
    always @(posedge i_clk) begin
        t_rsp e;
        t_rsp g;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            g = rsp_ch.data;
            if (expected_roots.size() == 0) begin
                report_mismatch("unexpected response", 0, g.root_count);
            end else begin
                e = expected_roots.pop_front();
                n_checked++;
                if (g.root_count != e.root_count)
                    report_mismatch("root_count", e.root_count, g.root_count);
                if (g.root_first != e.root_first)
                    report_mismatch("root_first", e.root_first, g.root_first);
                if (g.root_second != e.root_second)
                    report_mismatch("root_second", e.root_second, g.root_second);
                if (g.saturated != e.saturated)
                    report_mismatch("saturated", e.saturated, g.saturated);
            end
        end
    end

    // response side stalls, with calm stretches
    initial begin
        int stall;
        int k;
        rsp_ch.ready = 1'b0;
        k = 0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            stall = ((k / 64) % 3 == 1) ? 0 : $urandom_range(0, 12);
            k++;
            if (stall > 0) begin
                rsp_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_ch.ready = 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
        end
    end

    function automatic logic [CW-1:0] random_coef();
        case ($urandom_range(0, 5))
            0: return CW'($urandom);
            1: return CW'($signed($urandom & 32'hf_ffff) * ($urandom_range(0, 1) ? 1 : -1));
            2: return '0;
            3: return $urandom_range(0, 1) ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
            4: return CW'($urandom_range(0, 40) - 20) << FRAC_BITS;
            default: return CW'($urandom >> $urandom_range(0, 31));
        endcase
    endfunction

    // well formed sets from integer roots, mixed with noise
    function automatic t_req random_request();
        t_req r;
        int   x1, x2, ka;
        if ($urandom_range(0, 2) == 0) begin
            ka = $urandom_range(1, 8) * ($urandom_range(0, 1) ? 1 : -1);
            x1 = $urandom_range(0, 100) - 50;
            x2 = $urandom_range(0, 100) - 50;
            r.coef_square   = CW'(ka) << FRAC_BITS;
            r.coef_linear   = CW'(-ka * (x1 + x2)) << FRAC_BITS;
            r.coef_constant = CW'(ka * x1 * x2) << FRAC_BITS;
        end else begin
            r.coef_square   = random_coef();
            r.coef_linear   = random_coef();
            r.coef_constant = random_coef();
        end
        return r;
    endfunction

    task automatic send_request(input t_req r, input bit typed, input t_rsp rsp, input int gap);
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid = 1'b1;
        req_ch.data  = r;
        do @(posedge i_clk); while (!req_ch.ready);
        expected_roots.push_back(typed ? rsp : predict_roots(r));
        @(negedge i_clk);
    endtask

    // stimulus
    initial begin
        t_row rows[$];
        t_rsp none;
        int   i;
        int   wait_cycles;
        localparam logic [CW-1:0] ONE  = CW'(1) << FRAC_BITS;
        localparam logic [CW-1:0] QMAX = {1'b0, {(CW-1){1'b1}}};
        localparam logic [CW-1:0] QMIN = {1'b1, {(CW-1){1'b0}}};
        none = '0;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table: typed rows where the answer is plain
        rows.push_back('{'{'0, '0, '0}, 1, '{2'd1, '0, '0, 1'b0}});
        rows.push_back('{'{'0, '0, ONE}, 1, '{2'd0, '0, '0, 1'b0}});
        rows.push_back('{'{'0, '0, QMIN}, 1, '{2'd0, '0, '0, 1'b0}});
        rows.push_back('{'{'0, ONE, -(ONE << 1)}, 1, '{2'd1, ONE << 1, '0, 1'b0}});
        rows.push_back('{'{'0, CW'(1), QMAX}, 1, '{2'd1, QMIN, '0, 1'b1}});
        rows.push_back('{'{'0, -CW'(1), QMAX}, 1, '{2'd1, QMAX, '0, 1'b1}});
        rows.push_back('{'{ONE, '0, -ONE}, 1, '{2'd2, -ONE, ONE, 1'b0}});
        rows.push_back('{'{-ONE, '0, ONE}, 1, '{2'd2, ONE, -ONE, 1'b0}});
        rows.push_back('{'{ONE, '0, ONE}, 1, '{2'd0, '0, '0, 1'b0}});
        rows.push_back('{'{ONE, -(ONE << 1), ONE}, 1, '{2'd1, ONE, '0, 1'b0}});
        rows.push_back('{'{QMAX, QMAX, QMAX}, 0, none});
        rows.push_back('{'{QMIN, QMIN, QMIN}, 0, none});
        rows.push_back('{'{QMIN, QMAX, QMIN}, 0, none});
        rows.push_back('{'{QMAX, QMIN, QMIN}, 0, none});
        rows.push_back('{'{CW'(1), QMAX, '0}, 0, none});
        rows.push_back('{'{CW'(1), QMIN, CW'(1)}, 0, none});
        rows.push_back('{'{'0, QMIN, QMAX}, 0, none});
        rows.push_back('{'{'0, QMAX, QMIN}, 0, none});
        rows.push_back('{'{CW'(-1), CW'(3), CW'(-2)}, 0, none});
        rows.push_back('{'{ONE, CW'(1), '0}, 0, none});
        foreach (rows[j])
            send_request(rows[j].req, rows[j].typed, rows[j].rsp, $urandom_range(0, 3));

        // random part, with stretches of back to back requests
        for (i = 0; i < N_RANDOM; i++)
            send_request(random_request(), 0, none,
                         ((i / 50) % 3 == 2) ? 0 : $urandom_range(0, 12));
        req_ch.valid = 1'b0;

        wait (expected_roots.size() == 0);
        wait_cycles = 0;
        while (wait_cycles < DRAIN_CYCLES) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        $display("checked %0d responses from %0d directed and %0d random coefficient sets",
                 n_checked, rows.size(), N_RANDOM);
        if (n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/qes_pkg.sv
rtl/qes_if.sv
rtl/qes_sqrt_pipe.sv
rtl/qes_div_pipe.sv
rtl/quadratic_equation_solver.sv
tb/tb.sv
